[rtl/pol_pkg.sv]
`timescale 1ns / 1ps

package pol_pkg;

   // default sizes of the list
   localparam int DEPTH_DEFAULT      = 32;
   localparam int DATA_WIDTH_DEFAULT = 32;

   // fixed beat field widths
   localparam int CMD_W    = 3;
   localparam int POS_W    = 6;
   localparam int VALUE_W  = 32;
   localparam int STATUS_W = 2;
   localparam int COUNT_W  = 6;

   // cell index width, wide enough for the largest supported depth
   localparam int CELL_IDX_W = 8;

   // width used to sign extend stored elements
   localparam int EXT_W = 64;

   typedef enum logic [CMD_W-1:0] {
      CMD_INS_FRONT = 3'd0,
      CMD_INS_BACK  = 3'd1,
      CMD_INS_POS   = 3'd2,
      CMD_DEL_FRONT = 3'd3,
      CMD_DEL_BACK  = 3'd4,
      CMD_DEL_POS   = 3'd5,
      CMD_DUMP      = 3'd6
   } cmd_type;

   typedef enum logic [STATUS_W-1:0] {
      ST_OK     = 2'd0,
      ST_BADPOS = 2'd1,
      ST_FULL   = 2'd2,
      ST_EMPTY  = 2'd3
   } status_type;

   typedef enum logic [1:0] {
      OP_HOLD   = 2'd0,
      OP_INSERT = 2'd1,
      OP_DELETE = 2'd2,
      OP_ROTATE = 2'd3
   } cell_op_type;

   // control broadcast along the cell row
   typedef struct packed {
      cell_op_type           op;
      logic [CELL_IDX_W-1:0] idx;
      logic [CELL_IDX_W-1:0] last_idx;
   } cell_ctl_type;

endpackage

[rtl/pol_if.sv]
`timescale 1ns / 1ps

interface pol_req_if;
   logic                               valid;
   logic                               ready;
   logic        [pol_pkg::CMD_W-1:0]   command;
   logic        [pol_pkg::POS_W-1:0]   position;
   logic signed [pol_pkg::VALUE_W-1:0] value;

   modport source (output valid, command, position, value, input ready);
   modport sink   (input valid, command, position, value, output ready);
endinterface

interface pol_rsp_if;
   logic                                valid;
   logic                                ready;
   logic        [pol_pkg::STATUS_W-1:0] status;
   logic        [pol_pkg::COUNT_W-1:0]  element_count;
   logic signed [pol_pkg::VALUE_W-1:0]  element;
   logic                                last_result;

   modport source (output valid, status, element_count, element, last_result, input ready);
   modport sink   (input valid, status, element_count, element, last_result, output ready);
endinterface

[rtl/pol_cell.sv]
`timescale 1ns / 1ps

module pol_cell #(
   parameter int CELL_INDEX = 0,
   parameter int DATA_WIDTH = pol_pkg::DATA_WIDTH_DEFAULT
) (
   input  logic                    clock,
   input  pol_pkg::cell_ctl_type   ctl,
   input  logic [DATA_WIDTH-1:0]   ins_value,
   input  logic [DATA_WIDTH-1:0]   left_data,
   input  logic [DATA_WIDTH-1:0]   right_data,
   input  logic [DATA_WIDTH-1:0]   head_data,
   output logic [DATA_WIDTH-1:0]   data
);

   localparam logic [pol_pkg::CELL_IDX_W-1:0] MY_IDX = pol_pkg::CELL_IDX_W'(CELL_INDEX);

   logic [DATA_WIDTH-1:0] data_ff;
   logic [DATA_WIDTH-1:0] data_in;

   always_comb begin
      data_in = data_ff;
      case (ctl.op)
         pol_pkg::OP_INSERT: begin
            if (MY_IDX == ctl.idx) begin
               data_in = ins_value;
            end else if (MY_IDX > ctl.idx) begin
               data_in = left_data;
            end
         end
         pol_pkg::OP_DELETE: begin
            if (MY_IDX >= ctl.idx) begin
               data_in = right_data;
            end
         end
         pol_pkg::OP_ROTATE: begin
            // the tail of the list takes the head, the rest move one forward
            if (MY_IDX == ctl.last_idx) begin
               data_in = head_data;
            end else if (MY_IDX < ctl.last_idx) begin
               data_in = right_data;
            end
         end
         default: begin
            data_in = data_ff;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      data_ff <= data_in;
   end

   assign data = data_ff;

endmodule

[rtl/positional_ordered_list_core.sv]
`timescale 1ns / 1ps

// channel  | port    | direction | beat carries
// ---------+---------+-----------+-----------------------------------------------
// command  | req_bus | in        | command, position, value
// result   | rsp_bus | out       | status, element_count, element, last_result
//
// insert, delete and every other non-dump command give one beat;
// a new command is taken every cycle while the result register is free or drained
// a dump of n elements holds the input until its last beat: n beats, one per cycle
// while the result register is free, by rotating the cell row once per beat
// reset (synchronous, active high) empties the list and drops any pending beat
// a stalled result beat holds the result register and blocks new commands

module positional_ordered_list_core #(
   parameter int DEPTH      = pol_pkg::DEPTH_DEFAULT,
   parameter int DATA_WIDTH = pol_pkg::DATA_WIDTH_DEFAULT
) (
   input  logic             clock,
   input  logic             reset,
   pol_req_if.sink          req_bus,
   pol_rsp_if.source        rsp_bus
);

   // count has to hold DEPTH itself
   localparam int CNT_W = $clog2(DEPTH + 1);
   // common width for comparing the position against the count
   localparam int CMP_W = ((CNT_W > pol_pkg::POS_W) ? CNT_W : pol_pkg::POS_W) + 1;

   typedef enum logic {
      S_IDLE,
      S_DUMP
   } state_type;

   state_type  state_ff;
   logic [CNT_W-1:0] len_ff;
   logic [CNT_W-1:0] len_in;
   logic [CNT_W-1:0] dump_idx_ff;

   // result register
   logic                                rsp_valid_ff;
   logic [pol_pkg::STATUS_W-1:0]        rsp_status_ff;
   logic [pol_pkg::COUNT_W-1:0]         rsp_count_ff;
   logic signed [pol_pkg::VALUE_W-1:0]  rsp_element_ff;
   logic                                rsp_last_ff;

   pol_pkg::cell_ctl_type  ctl;
   pol_pkg::status_type    status_in;
   pol_pkg::cmd_type       cmd;

   logic slot_free;
   logic req_fire;
   logic go_dump;
   logic dump_fire;
   logic dump_last;
   logic rsp_load;
   logic full;
   logic [CMP_W-1:0] pos_x;
   logic [CMP_W-1:0] len_x;

   logic [DATA_WIDTH-1:0]         cell_data [DEPTH];
   logic [DATA_WIDTH-1:0]         ins_value;
   logic signed [pol_pkg::EXT_W-1:0]      value_ext;
   logic signed [DATA_WIDTH-1:0]          head_s;
   logic signed [pol_pkg::EXT_W-1:0]      head_ext;

   // -------------------------------------------------------------------------
   // handshake
   // -------------------------------------------------------------------------

   // the result register is free when empty or being taken this cycle
   assign slot_free     = !rsp_valid_ff || rsp_bus.ready;
   assign req_bus.ready = (state_ff == S_IDLE) && slot_free;
   assign req_fire      = req_bus.valid && req_bus.ready;

   assign cmd   = pol_pkg::cmd_type'(req_bus.command);
   assign pos_x = CMP_W'(req_bus.position);
   assign len_x = CMP_W'(len_ff);
   assign full  = (len_ff == CNT_W'(DEPTH));

   // insert value: sign extend the 32-bit beat value, keep DATA_WIDTH bits
   assign value_ext = pol_pkg::EXT_W'(req_bus.value);
   assign ins_value = value_ext[DATA_WIDTH-1:0];

   // dump element: head cell taken as signed and widened
   assign head_s   = cell_data[0];
   assign head_ext = pol_pkg::EXT_W'(head_s);

   assign dump_last = (dump_idx_ff == (len_ff - CNT_W'(1)));
   assign dump_fire = (state_ff == S_DUMP) && slot_free;
   assign rsp_load  = (req_fire && !go_dump) || dump_fire;

   // -------------------------------------------------------------------------
   // command decode and cell row control
   // -------------------------------------------------------------------------

   always_comb begin
      ctl.op       = pol_pkg::OP_HOLD;
      ctl.idx      = '0;
      ctl.last_idx = pol_pkg::CELL_IDX_W'(len_ff - CNT_W'(1));
      len_in       = len_ff;
      status_in    = pol_pkg::ST_OK;
      go_dump      = 1'b0;

      if (req_fire) begin
         case (cmd)
            pol_pkg::CMD_INS_FRONT,
            pol_pkg::CMD_INS_BACK,
            pol_pkg::CMD_INS_POS: begin
               // full list is checked ahead of the position
               if (full) begin
                  status_in = pol_pkg::ST_FULL;
               end else if (cmd == pol_pkg::CMD_INS_FRONT) begin
                  ctl.op = pol_pkg::OP_INSERT;
                  ctl.idx = '0;
                  len_in = len_ff + CNT_W'(1);
               end else if (cmd == pol_pkg::CMD_INS_BACK) begin
                  ctl.op = pol_pkg::OP_INSERT;
                  ctl.idx = pol_pkg::CELL_IDX_W'(len_ff);
                  len_in = len_ff + CNT_W'(1);
               end else if ((pos_x == '0) || (pos_x > (len_x + CMP_W'(1)))) begin
                  status_in = pol_pkg::ST_BADPOS;
               end else begin
                  ctl.op = pol_pkg::OP_INSERT;
                  ctl.idx = pol_pkg::CELL_IDX_W'(pos_x - CMP_W'(1));
                  len_in = len_ff + CNT_W'(1);
               end
            end
            pol_pkg::CMD_DEL_FRONT,
            pol_pkg::CMD_DEL_BACK,
            pol_pkg::CMD_DEL_POS: begin
               // empty list wins over a bad position
               if (len_ff == '0) begin
                  status_in = pol_pkg::ST_EMPTY;
               end else if (cmd == pol_pkg::CMD_DEL_FRONT) begin
                  ctl.op = pol_pkg::OP_DELETE;
                  ctl.idx = '0;
                  len_in = len_ff - CNT_W'(1);
               end else if (cmd == pol_pkg::CMD_DEL_BACK) begin
                  ctl.op = pol_pkg::OP_DELETE;
                  ctl.idx = pol_pkg::CELL_IDX_W'(len_ff - CNT_W'(1));
                  len_in = len_ff - CNT_W'(1);
               end else if ((pos_x == '0) || (pos_x > len_x)) begin
                  status_in = pol_pkg::ST_BADPOS;
               end else begin
                  ctl.op = pol_pkg::OP_DELETE;
                  ctl.idx = pol_pkg::CELL_IDX_W'(pos_x - CMP_W'(1));
                  len_in = len_ff - CNT_W'(1);
               end
            end
            pol_pkg::CMD_DUMP: begin
               if (len_ff == '0) begin
                  status_in = pol_pkg::ST_EMPTY;
               end else begin
                  go_dump = 1'b1;
               end
            end
            default: begin
               // unused code: list untouched, plain ok beat
               status_in = pol_pkg::ST_OK;
            end
         endcase
      end else if (dump_fire) begin
         // one rotation per dump beat; after len beats the row is back in order
         ctl.op = pol_pkg::OP_ROTATE;
      end
   end

   // -------------------------------------------------------------------------
   // cell row
   // -------------------------------------------------------------------------

   for (genvar j = 0; j < DEPTH; j++) begin : g_cell
      logic [DATA_WIDTH-1:0] left_data;
      logic [DATA_WIDTH-1:0] right_data;

      if (j == 0) begin : g_first
         assign left_data = cell_data[0];
      end else begin : g_inner_left
         assign left_data = cell_data[j-1];
      end

      if (j == DEPTH - 1) begin : g_last
         assign right_data = cell_data[j];
      end else begin : g_inner_right
         assign right_data = cell_data[j+1];
      end

      pol_cell #(
         .CELL_INDEX (j),
         .DATA_WIDTH (DATA_WIDTH)
      ) u_cell (
         .clock      (clock),
         .ctl        (ctl),
         .ins_value  (ins_value),
         .left_data  (left_data),
         .right_data (right_data),
         .head_data  (cell_data[0]),
         .data       (cell_data[j])
      );
   end

   // -------------------------------------------------------------------------
   // state, count and result register
   // -------------------------------------------------------------------------

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         len_ff       <= '0;
         dump_idx_ff  <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         len_ff <= len_in;

         if (rsp_load) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_bus.ready) begin
            rsp_valid_ff <= 1'b0;
         end

         case (state_ff)
            S_IDLE: begin
               dump_idx_ff <= '0;
               if (go_dump) begin
                  state_ff <= S_DUMP;
               end
            end
            S_DUMP: begin
               if (dump_fire) begin
                  dump_idx_ff <= dump_idx_ff + CNT_W'(1);
                  if (dump_last) begin
                     state_ff <= S_IDLE;
                  end
               end
            end
            default: begin
               state_ff <= S_IDLE;
            end
         endcase

         // result payload
         if (dump_fire) begin
            rsp_status_ff  <= pol_pkg::ST_OK;
            rsp_count_ff   <= pol_pkg::COUNT_W'(len_ff);
            rsp_element_ff <= head_ext[pol_pkg::VALUE_W-1:0];
            rsp_last_ff    <= dump_last;
         end else if (rsp_load) begin
            rsp_status_ff  <= status_in;
            rsp_count_ff   <= pol_pkg::COUNT_W'(len_in);
            rsp_element_ff <= '0;
            rsp_last_ff    <= 1'b1;
         end
      end
   end

   assign rsp_bus.valid         = rsp_valid_ff;
   assign rsp_bus.status        = rsp_status_ff;
   assign rsp_bus.element_count = rsp_count_ff;
   assign rsp_bus.element       = rsp_element_ff;
   assign rsp_bus.last_result   = rsp_last_ff;

`ifndef NO_ASSERTIONS
   // count never runs past the row
   a_len_bound: assert property (@(posedge clock) disable iff (reset)
      len_ff <= CNT_W'(DEPTH))
      else $error("list count above depth");

   // no command taken while a dump is running
   a_no_req_in_dump: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_DUMP) |-> !req_bus.ready)
      else $error("command accepted during dump");

   // a dump leaves the count alone
   a_dump_len_stable: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_DUMP) |=> (len_ff == $past(len_ff)))
      else $error("count changed during dump");

   // the final dump beat returns to idle
   a_dump_end: assert property (@(posedge clock) disable iff (reset)
      (dump_fire && dump_last) |=> (state_ff == S_IDLE))
      else $error("dump did not finish after last beat");

   // a dump never starts on an empty list
   a_dump_nonempty: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_DUMP) |-> (len_ff != '0))
      else $error("dump running on empty list");
`endif

endmodule
